// ===== design/sts_pkg.sv =====
// Shared types and constants for the S-expression token splitter.
`timescale 1ns / 1ps
`default_nettype none

package sts_pkg;

  // Token kind codes
  localparam logic [2:0] KIND_LPAREN = 3'd0;
  localparam logic [2:0] KIND_RPAREN = 3'd1;
  localparam logic [2:0] KIND_SPACES = 3'd2;
  localparam logic [2:0] KIND_STRING = 3'd3;
  localparam logic [2:0] KIND_NUMBER = 3'd4;
  localparam logic [2:0] KIND_SYMBOL = 3'd5;
  localparam logic [2:0] KIND_IDLE   = 3'd7;

  // Character codes
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_DOT    = 8'h2E;

  localparam int FIELD_BITS = 16;

  typedef struct packed {
    logic [2:0]            kind;
    logic [FIELD_BITS-1:0] start;
    logic [FIELD_BITS-1:0] length;
    logic                  unterm;
    logic                  done;
    logic                  last;
  } res_t;

endpackage

`default_nettype wire

// ===== design/sexpr_token_splitter.sv =====
// S-expression token splitter: byte-at-a-time lexer with a small result queue.
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   Input channel (in_*): one text byte per beat, in_final marks the last
//   byte of a text. A beat is taken when in_valid is high and in_stall low.
//   Result channel (out_*): one finished token per beat (kind, start offset,
//   length, unterminated-string flag, end-of-text flag, last-of-byte flag).
//   A byte yields zero, one or two results.
// Timing
//   The token state is updated in the cycle a byte is accepted and its
//   results are written into a four-entry result queue at that edge, from
//   which out_* presents them in order. One byte is accepted per cycle
//   while the queue has room for two results; the result port drains one
//   token per cycle while out_stall is low, which bounds the rate for bytes
//   that close one token and report another.
// Reset
//   rst_n (synchronous, active low) empties the queue, closes any open
//   token and returns the offset counter to zero.
// Back-pressure
//   While out_stall is high the head result holds; in_stall rises once
//   fewer than two queue slots are free.
module sexpr_token_splitter #(
  parameter int OFFSET_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_byte,
  input  wire logic        in_final,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_token_kind,
  output logic [15:0]      out_token_start,
  output logic [15:0]      out_token_length,
  output logic             out_unterminated,
  output logic             out_stream_done,
  output logic             out_run_last
);

  localparam logic [OFFSET_BITS-1:0] OFF_MAX = {OFFSET_BITS{1'b1}};

  // Token state
  logic [2:0]             kind_r,  kind_nxt;
  logic [OFFSET_BITS-1:0] start_r, start_nxt;
  logic [OFFSET_BITS-1:0] len_r,   len_nxt;
  logic [OFFSET_BITS-1:0] pos_r,   pos_nxt;

  // Result queue
  sts_pkg::res_t fifo_r [4];
  logic [1:0]    wr_ptr_r, rd_ptr_r;
  logic [2:0]    cnt_r, cnt_nxt;

  logic          in_fire, out_fire;
  sts_pkg::res_t res0, res1;
  logic [1:0]    res_n;
  sts_pkg::res_t head;

  assign in_fire  = in_valid && !in_stall;
  assign out_fire = out_valid && !out_stall;
  assign in_stall = (cnt_r > 3'd2);
  assign out_valid = (cnt_r != 3'd0);

  function automatic logic [OFFSET_BITS-1:0] sat_inc(input logic [OFFSET_BITS-1:0] v);
    sat_inc = (v == OFF_MAX) ? v : v + OFFSET_BITS'(1);
  endfunction

  function automatic sts_pkg::res_t mk_res(input logic [2:0] k,
                                           input logic [OFFSET_BITS-1:0] s,
                                           input logic [OFFSET_BITS-1:0] l,
                                           input logic u);
    sts_pkg::res_t r;
    r.kind   = k;
    r.start  = sts_pkg::FIELD_BITS'(s);
    r.length = sts_pkg::FIELD_BITS'(l);
    r.unterm = u;
    r.done   = 1'b0;
    r.last   = 1'b0;
    mk_res = r;
  endfunction

  // Byte classification and token step
  always_comb begin
    logic [2:0]    cls;
    logic          is_digit;
    logic          ends;
    logic          handled;
    logic          a_v, b_v, c_v;
    sts_pkg::res_t a_r, b_r, c_r, sec;
    logic          sec_v;

    is_digit = (in_byte inside {[sts_pkg::CH_ZERO:sts_pkg::CH_NINE]});
    if (in_byte == sts_pkg::CH_LPAREN)      cls = sts_pkg::KIND_LPAREN;
    else if (in_byte == sts_pkg::CH_RPAREN) cls = sts_pkg::KIND_RPAREN;
    else if (in_byte == sts_pkg::CH_SPACE)  cls = sts_pkg::KIND_SPACES;
    else if (in_byte == sts_pkg::CH_QUOTE)  cls = sts_pkg::KIND_STRING;
    else if (is_digit)                      cls = sts_pkg::KIND_NUMBER;
    else                                    cls = sts_pkg::KIND_SYMBOL;

    kind_nxt  = kind_r;
    start_nxt = start_r;
    len_nxt   = len_r;
    ends      = 1'b0;
    handled   = 1'b0;
    a_v = 1'b0; b_v = 1'b0; c_v = 1'b0;
    a_r = mk_res(kind_r, start_r, len_r, 1'b0);

    // Continue or close the open token
    case (kind_r)
      sts_pkg::KIND_IDLE: ;
      sts_pkg::KIND_SPACES: ends = (in_byte != sts_pkg::CH_SPACE);
      sts_pkg::KIND_STRING: begin
        if (in_byte == sts_pkg::CH_QUOTE) begin
          a_v      = 1'b1;
          a_r      = mk_res(sts_pkg::KIND_STRING, start_r, sat_inc(len_r), 1'b0);
          kind_nxt = sts_pkg::KIND_IDLE;
          handled  = 1'b1;
        end
      end
      sts_pkg::KIND_NUMBER: ends = !(is_digit || in_byte == sts_pkg::CH_DOT);
      default: ends = (in_byte == sts_pkg::CH_SPACE) ||
                      (in_byte == sts_pkg::CH_LPAREN) ||
                      (in_byte == sts_pkg::CH_RPAREN);
    endcase

    if (kind_r != sts_pkg::KIND_IDLE) begin
      if (ends) begin
        a_v      = 1'b1;
        kind_nxt = sts_pkg::KIND_IDLE;
      end else if (!handled) begin
        len_nxt = sat_inc(len_r);
        handled = 1'b1;
      end
    end

    // Start a new token; parens report at once
    b_r = mk_res(cls, pos_r, OFFSET_BITS'(1), 1'b0);
    if (!handled) begin
      if (cls == sts_pkg::KIND_LPAREN || cls == sts_pkg::KIND_RPAREN) begin
        b_v = 1'b1;
      end else begin
        kind_nxt  = cls;
        start_nxt = pos_r;
        len_nxt   = OFFSET_BITS'(1);
      end
    end

    pos_nxt = sat_inc(pos_r);

    // End of text: flush whatever is still open
    c_r = mk_res(kind_nxt, start_nxt, len_nxt, kind_nxt == sts_pkg::KIND_STRING);
    if (in_final) begin
      c_v       = (kind_nxt != sts_pkg::KIND_IDLE);
      kind_nxt  = sts_pkg::KIND_IDLE;
      start_nxt = '0;
      len_nxt   = '0;
      pos_nxt   = '0;
    end

    // Compact up to two results
    sec_v = b_v || c_v;
    sec   = b_v ? b_r : c_r;
    res0  = a_v ? a_r : sec;
    res1  = sec;
    res_n = {1'b0, a_v} + {1'b0, sec_v};
    if (res_n == 2'd2) begin
      res1.last = 1'b1;
      res1.done = in_final;
    end else begin
      res0.last = 1'b1;
      res0.done = in_final;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r  <= sts_pkg::KIND_IDLE;
      start_r <= '0;
      len_r   <= '0;
      pos_r   <= '0;
    end else if (in_fire) begin
      kind_r  <= kind_nxt;
      start_r <= start_nxt;
      len_r   <= len_nxt;
      pos_r   <= pos_nxt;
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (in_fire && res_n != 2'd0) begin
      fifo_r[wr_ptr_r] <= res0;
    end
    if (in_fire && res_n == 2'd2) begin
      fifo_r[wr_ptr_r + 2'd1] <= res1;
    end
  end

  always_comb begin
    cnt_nxt = cnt_r + (in_fire ? {1'b0, res_n} : 3'd0) - {2'b00, out_fire};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (in_fire) wr_ptr_r <= wr_ptr_r + res_n;
      if (out_fire) rd_ptr_r <= rd_ptr_r + 2'd1;
      cnt_r <= cnt_nxt;
    end
  end

  assign head             = fifo_r[rd_ptr_r];
  assign out_token_kind   = head.kind;
  assign out_token_start  = head.start;
  assign out_token_length = head.length;
  assign out_unterminated = head.unterm;
  assign out_stream_done  = head.done;
  assign out_run_last     = head.last;

  // Checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'd4)
    else $error("result queue overflow");

  a_ptr_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_ptr_r - rd_ptr_r) == cnt_r[1:0])
    else $error("queue pointers disagree with count");

  a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_final |=> kind_r == sts_pkg::KIND_IDLE && pos_r == '0)
    else $error("token state not cleared after end of text");

  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stream_done |-> out_run_last)
    else $error("end of text not on last result of its byte");

endmodule

`default_nettype wire
